@@ rtl/core/srlp_pkg.sv @@
// ----------------------------------------------------------------------------
// srlp_pkg: shared types and constants for the sensor record line parser
// Holds the request and result payload structs and the character codes
// that the parser recognizes.
// ----------------------------------------------------------------------------
package srlp_pkg;

  localparam int unsigned OUT_BITS = 16;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } srlp_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] year;
    logic [OUT_BITS-1:0] month;
    logic [OUT_BITS-1:0] day;
    logic [OUT_BITS-1:0] hour;
    logic [OUT_BITS-1:0] minute;
    logic [OUT_BITS-1:0] temperature;
    logic                more_data;
  } srlp_out_t;

endpackage

@@ rtl/core/srlp_field_update.sv @@
// ----------------------------------------------------------------------------
// srlp_field_update: saturating decimal accumulate
// Computes acc * 10 + digit and clamps the result at the all-ones value.
// ----------------------------------------------------------------------------
module srlp_field_update #(
  parameter int unsigned FIELD_BITS = 16
) (
  input  logic [FIELD_BITS-1:0] acc_in,
  input  logic [3:0]            digit,
  output logic [FIELD_BITS-1:0] acc_out
);

  localparam int unsigned WIDE_BITS = FIELD_BITS + 4;

  logic [WIDE_BITS-1:0] acc_wide;
  logic [WIDE_BITS-1:0] sum;

  // Times ten is a shift by three plus a shift by one.
  assign acc_wide = WIDE_BITS'(acc_in);
  assign sum      = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(digit);

  assign acc_out = (sum[WIDE_BITS-1:FIELD_BITS] != '0) ? '1 : sum[FIELD_BITS-1:0];

endmodule

@@ rtl/core/sensor_record_line_parser_unit.sv @@
// ----------------------------------------------------------------------------
// sensor_record_line_parser_unit: byte-stream parser for sensor records
// The in_ channel carries one text byte per request (or an end-of-data flag).
// Semicolon-separated decimal fields are accumulated with saturation; a
// newline or zero byte emits the record with more_data set, while end of data
// or any byte of 0x80 and above emits it with more_data clear. Each emit
// clears all accumulators and the field index.
// Throughput is one byte per clock while in_ready is high. A request is
// first captured in an input register; when it moves on, the accumulators
// are updated and, for a terminator, the result register is loaded and
// out_valid rises, and the record can then be taken on out_. Bytes that
// produce no result keep flowing while an earlier result waits on
// out_ready; only a terminator held in the input register waits for the
// result register to free up, and then in_ready drops. Reset (rst_n low,
// synchronous) empties both registers, zeroes all accumulators and returns
// the field index to the first field.
// ----------------------------------------------------------------------------
module sensor_record_line_parser_unit #(
  parameter int unsigned NUM_FIELDS = 6,
  parameter int unsigned FIELD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srlp_pkg::srlp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srlp_pkg::srlp_out_t out_data
);

  import srlp_pkg::*;

  // The index counts one past the last field, where it parks on extra
  // semicolons.
  localparam int unsigned IDX_W      = $clog2(NUM_FIELDS + 1);
  localparam int unsigned OUT_FIELDS = 6;

  // Input register.
  logic     in_vld_r;
  srlp_in_t in_data_r;

  // Parser state.
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_nxt;
  logic [FIELD_BITS-1:0] acc_r   [NUM_FIELDS];
  logic [FIELD_BITS-1:0] acc_nxt [NUM_FIELDS];

  // Result register.
  logic      out_vld_r;
  srlp_out_t out_data_r;
  srlp_out_t out_data_nxt;

  // Decode of the byte sitting in the input register.
  logic                  is_end;
  logic                  is_line;
  logic                  is_digit;
  logic                  is_semi;
  logic                  emits;
  logic                  in_field;
  logic [7:0]            digit_wide;
  logic [FIELD_BITS-1:0] acc_sel;
  logic [FIELD_BITS-1:0] acc_upd;
  logic                  stall;
  logic                  fire;

  assign is_end     = in_data_r.end_of_data || in_data_r.data_byte[7];
  assign is_line    = (in_data_r.data_byte == CH_NL) || (in_data_r.data_byte == CH_NUL);
  assign is_digit   = in_data_r.data_byte inside {[CH_0:CH_9]};
  assign is_semi    = in_data_r.data_byte == CH_SEMI;
  assign emits      = is_end || is_line;
  assign in_field   = idx_r < IDX_W'(NUM_FIELDS);
  assign digit_wide = in_data_r.data_byte - CH_0;

  // A terminator can only move on when the result register is free or
  // being drained this cycle; every other byte moves on at once.
  assign stall    = in_vld_r && emits && out_vld_r && !out_ready;
  assign fire     = in_vld_r && !stall;
  assign in_ready = !in_vld_r || !stall;

  // Pick the accumulator of the current field for the shared update unit.
  always_comb begin
    acc_sel = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (idx_r == IDX_W'(i)) begin
        acc_sel = acc_r[i];
      end
    end
  end

  srlp_field_update #(
    .FIELD_BITS (FIELD_BITS)
  ) u_update (
    .acc_in  (acc_sel),
    .digit   (digit_wide[3:0]),
    .acc_out (acc_upd)
  );

  // Next state of the index and accumulators. A terminator clears the
  // record after it has been copied into the result.
  always_comb begin
    idx_nxt = idx_r;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      acc_nxt[i] = acc_r[i];
    end
    if (fire) begin
      if (emits) begin
        idx_nxt = '0;
        for (int i = 0; i < NUM_FIELDS; i++) begin
          acc_nxt[i] = '0;
        end
      end else if (is_digit && in_field) begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (idx_r == IDX_W'(i)) begin
            acc_nxt[i] = acc_upd;
          end
        end
      end else if (is_semi && in_field) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  // Result payload: the low output bits of each configured field, zero for
  // fields that the record does not have.
  always_comb begin
    logic [OUT_BITS-1:0] vals [OUT_FIELDS];
    for (int j = 0; j < OUT_FIELDS; j++) begin
      vals[j] = '0;
    end
    for (int j = 0; j < OUT_FIELDS; j++) begin
      if (j < NUM_FIELDS) begin
        vals[j] = OUT_BITS'(acc_r[j]);
      end
    end
    out_data_nxt.year        = vals[0];
    out_data_nxt.month       = vals[1];
    out_data_nxt.day         = vals[2];
    out_data_nxt.hour        = vals[3];
    out_data_nxt.minute      = vals[4];
    out_data_nxt.temperature = vals[5];
    out_data_nxt.more_data   = !is_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      idx_r <= idx_nxt;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
      if (fire && emits) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (fire && emits) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sensor_record_line_parser_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sensor_record_line_parser_unit_tb: self-checking bench for the record parser
// Sends text bytes and end-of-data requests into the parser, predicts each
// emitted record with a behavioral copy of the field accumulators, and checks
// every record on out_ field by field. Directed tests cover the terminators,
// saturation, the field index limit and ignored bytes. Random records follow
// under four sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module sensor_record_line_parser_unit_tb;
  import srlp_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned NUM_FIELDS     = 6;
  localparam int unsigned FIELD_MAX      = 65535;
  localparam int unsigned PHASE_ITEMS    = 430;

  // Character codes that the parser must ignore or treat as end of data.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_HIGH_LO = 8'h80;
  localparam logic [7:0] CH_HIGH_HI = 8'hFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  srlp_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  srlp_out_t out_data;

  // Behavioral parser state: current field and one accumulator per field.
  logic [2:0]  cur_field;
  int unsigned field_value [NUM_FIELDS];

  // Records that the parser owes us, oldest first.
  srlp_out_t   pending_records [$];
  srlp_out_t   expected_rec;

  int unsigned mismatch_count;
  int unsigned accepted_requests;
  int unsigned gap_pct;
  int unsigned stall_pct;

  sensor_record_line_parser_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [OUT_BITS-1:0] got,
                             input logic [OUT_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Queues the record built so far and starts a fresh one.
  task automatic close_record(input logic more);
    srlp_out_t rec;
    rec.year        = field_value[0][15:0];
    rec.month       = field_value[1][15:0];
    rec.day         = field_value[2][15:0];
    rec.hour        = field_value[3][15:0];
    rec.minute      = field_value[4][15:0];
    rec.temperature = field_value[5][15:0];
    rec.more_data   = more;
    pending_records.push_back(rec);
    cur_field = '0;
    foreach (field_value[i]) field_value[i] = 0;
  endtask

  // Applies one accepted request to the behavioral parser state.
  task automatic advance_parser(input srlp_in_t req);
    int unsigned v;
    if (req.end_of_data || req.data_byte[7]) begin
      close_record(1'b0);
    end else if (req.data_byte == CH_NL || req.data_byte == CH_NUL) begin
      close_record(1'b1);
    end else if (req.data_byte >= CH_0 && req.data_byte <= CH_9) begin
      if (cur_field < NUM_FIELDS) begin
        v = field_value[cur_field] * 10 + int'(req.data_byte - CH_0);
        field_value[cur_field] = (v > FIELD_MAX) ? FIELD_MAX : v;
      end
    end else if (req.data_byte == CH_SEMI) begin
      if (cur_field < NUM_FIELDS) cur_field++;
    end
  endtask

  // Sends one request. The task is entered and left just after a rising edge,
  // so in_valid stays high between back-to-back requests and is only lowered
  // when the sender decides to idle.
  task automatic send_byte(input logic [7:0] data_byte, input logic end_flag);
    srlp_in_t req;
    req.data_byte   = data_byte;
    req.end_of_data = end_flag;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_parser(req);
    accepted_requests++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i], 1'b0);
  endtask

  // Every way a record can end; end of data wins over a newline byte.
  task automatic test_terminators();
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_NL, 1'b1);
    send_byte(CH_HIGH_LO, 1'b0);
    send_byte(CH_HIGH_HI, 1'b0);
  endtask

  // Six nines overflow sixteen bits and must stick at the maximum.
  task automatic test_saturation();
    send_text("999999");
    send_byte(CH_NL, 1'b0);
  endtask

  // All six fields get a value; the seventh one is past the end and dropped.
  task automatic test_field_limit();
    send_text("1;2;3;4;5;6;7");
    send_byte(CH_NUL, 1'b0);
  endtask

  // A space and the bytes next to the digit range are ignored, as is the byte
  // of an end-of-data request.
  task automatic test_ignored_bytes();
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SLASH, 1'b0);
    send_byte(CH_COLON, 1'b0);
    send_byte(8'(CH_0 + 5), 1'b1);
  endtask

  // Mostly well-formed lines with random digits, plus occasional short or
  // long lines and stray bytes inside numbers; the caller adds noise between lines.
  task automatic send_random_record();
    int unsigned n_fields;
    int unsigned n_digits;
    n_fields = ($urandom_range(9) == 0) ? $urandom_range(8) : NUM_FIELDS;
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) send_byte(CH_SEMI, 1'b0);
      n_digits = ($urandom_range(19) == 0) ? $urandom_range(9) : $urandom_range(1, 4);
      repeat (n_digits) begin
        if ($urandom_range(15) == 0) send_byte(8'($urandom_range(127)), 1'b0);
        send_byte(8'(CH_0 + $urandom_range(9)), 1'b0);
      end
    end
    case ($urandom_range(9))
      0: send_byte(CH_NUL, 1'b0);
      1: send_byte(8'($urandom_range(255)), 1'b1);
      2: send_byte(8'($urandom_range(CH_HIGH_LO, CH_HIGH_HI)), 1'b0);
      default: send_byte(CH_NL, 1'b0);
    endcase
  endtask

  task automatic test_random_records(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = accepted_requests + n_items;
    while (accepted_requests < stop_at) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      end else begin
        send_random_record();
      end
    end
  endtask

  // The receiver decides each cycle whether to accept a record.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Each record handed over on out_ is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_records.size() == 0) begin
        report_mismatch("record arrived with none pending");
      end else begin
        expected_rec = pending_records.pop_front();
        check_field("year",        out_data.year,        expected_rec.year);
        check_field("month",       out_data.month,       expected_rec.month);
        check_field("day",         out_data.day,         expected_rec.day);
        check_field("hour",        out_data.hour,        expected_rec.hour);
        check_field("minute",      out_data.minute,      expected_rec.minute);
        check_field("temperature", out_data.temperature, expected_rec.temperature);
        check_field("more_data",   OUT_BITS'(out_data.more_data),
                    OUT_BITS'(expected_rec.more_data));
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timed out with %0d records pending", pending_records.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data           = '0;
    out_ready         = 1'b0;
    mismatch_count    = 0;
    accepted_requests = 0;
    gap_pct           = 0;
    stall_pct         = 0;
    cur_field         = '0;
    foreach (field_value[i]) field_value[i] = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_terminators();
    test_saturation();
    test_field_limit();
    test_ignored_bytes();

    // No idling, then an idle sender, then a stalling receiver, then both.
    gap_pct = 0;  stall_pct = 0;
    test_random_records(PHASE_ITEMS);
    gap_pct = 56; stall_pct = 0;
    test_random_records(PHASE_ITEMS);
    gap_pct = 0;  stall_pct = 56;
    test_random_records(PHASE_ITEMS);
    gap_pct = 10; stall_pct = 10;
    test_random_records(PHASE_ITEMS);

    // Close any record left open so the tail of the stream is checked too.
    send_byte(CH_NL, 1'b0);
    in_valid  <= 1'b0;
    stall_pct = 0;

    wait (pending_records.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
